### sv/swt_pkg.sv
`default_nettype none
package swt_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   localparam int unsigned MAX_RESULTS = 3;

   // Quoting state carried from one byte to the next.
   typedef struct packed {
      logic escape_next;
      logic in_single;
      logic in_double;
      logic pending_backslash;
      logic word_open;
   } tok_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       word_end;
   } res_entry_type;

   // All results caused by one input byte, entry 0 delivered first.
   typedef struct packed {
      logic [1:0]          count;
      res_entry_type [2:0] entry;
   } res_set_type;

   function automatic res_set_type push_result(res_set_type s, logic [7:0] b, logic e);
      res_set_type r;
      r = s;
      if (s.count != 2'd3) begin
         r.entry[s.count].out_byte = b;
         r.entry[s.count].word_end = e;
         r.count                   = s.count + 2'd1;
      end
      return r;
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   endfunction

endpackage
`default_nettype wire

### sv/swt_if.sv
`default_nettype none
interface swt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface swt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       word_end;
   logic       last;

   modport source (output valid, output out_byte, output word_end, output last, input ready);
   modport sink   (input valid, input out_byte, input word_end, input last, output ready);
endinterface
`default_nettype wire

### sv/swt_step.sv
`default_nettype none
// Next-state and result logic for one byte of the command line.
module swt_step
   import swt_pkg::*;
(
   input  tok_state_type state_cur,
   input  logic [7:0]    in_byte,
   input  logic          end_of_input,
   output tok_state_type state_nxt,
   output res_set_type   results
);

   always_comb begin
      tok_state_type s;
      res_set_type   r;
      logic          do_handle;

      s         = state_cur;
      r         = '0;
      do_handle = 1'b0;

      if (s.escape_next) begin
         s.escape_next       = 1'b0;
         s.pending_backslash = 1'b0;
         r                   = push_result(r, in_byte, 1'b0);
         s.word_open         = 1'b1;
      end else if (s.pending_backslash) begin
         s.pending_backslash = 1'b0;
         if (in_byte == CH_DQUOTE || in_byte == CH_BACKSLASH || in_byte == CH_DOLLAR) begin
            r = push_result(r, in_byte, 1'b0);
         end else begin
            r         = push_result(r, CH_BACKSLASH, 1'b0);
            do_handle = 1'b1;
         end
         s.word_open = 1'b1;
      end else begin
         do_handle = 1'b1;
      end

      if (do_handle) begin
         if (in_byte == CH_BACKSLASH) begin
            if (s.in_single) begin
               r           = push_result(r, in_byte, 1'b0);
               s.word_open = 1'b1;
            end else if (s.in_double) begin
               if (end_of_input) begin
                  r           = push_result(r, in_byte, 1'b0);
                  s.word_open = 1'b1;
               end else begin
                  s.pending_backslash = 1'b1;
               end
            end else begin
               s.escape_next = 1'b1;
            end
         end else if (in_byte == CH_SQUOTE && !s.in_double) begin
            s.in_single = ~s.in_single;
         end else if (in_byte == CH_DQUOTE && !s.in_single) begin
            s.in_double = ~s.in_double;
         end else if (is_space(in_byte) && !s.in_single && !s.in_double) begin
            if (s.word_open) begin
               r           = push_result(r, 8'h00, 1'b1);
               s.word_open = 1'b0;
            end
         end else begin
            r           = push_result(r, in_byte, 1'b0);
            s.word_open = 1'b1;
         end
      end

      // End of line closes an open word and returns to the idle state.
      if (end_of_input) begin
         if (s.word_open) begin
            r = push_result(r, 8'h00, 1'b1);
         end
         s = '0;
      end

      state_nxt = s;
      results   = r;
   end

endmodule
`default_nettype wire

### sv/swt_outq.sv
`default_nettype none
// Result register holding the results of one byte; they leave one per beat.
module swt_outq
   import swt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  res_set_type   load_set,
   input  logic          pop,
   output res_entry_type head,
   output logic [1:0]    count
);

   res_entry_type [2:0] entry_ff, entry_in;
   logic [1:0]          count_ff, count_in;

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (load) begin
         entry_in = load_set.entry;
         count_in = load_set.count;
      end else if (pop) begin
         entry_in = {entry_ff[2], entry_ff[2], entry_ff[1]};
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = entry_ff[0];
   assign count = count_ff;

endmodule
`default_nettype wire

### sv/shell_word_tokenizer.sv
`default_nettype none
// Shell word tokenizer.
// The req_chan channel carries one command-line byte per beat, with
// end_of_input set on the final byte of a line. The rsp_chan channel returns
// the words: one beat per kept character (word_end low), then a marker beat
// with word_end high and out_byte zero after each word. The flag last marks
// the final beat caused by one input byte; a byte that causes nothing (a
// quote, a lone backslash, extra whitespace) returns no beat at all.
// A byte causes at most three beats. Its results are decided in the cycle it
// is accepted, registered, and visible on rsp_chan in the next cycle. The
// result register drains one beat per cycle while the receiver is ready, and
// a new byte is taken as soon as the register holds at most one beat that
// leaves in the same cycle. With the receiver ready, a byte with zero or one
// result is taken every cycle; one with more results holds off the next byte.
// Synchronous reset empties the result register and clears all quoting
// state. When the receiver stalls, the pending beat holds and req_chan.ready
// drops until the last beat of the current byte has been taken.
module shell_word_tokenizer
   import swt_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   swt_req_if.sink   req_chan,
   swt_rsp_if.source rsp_chan
);

   tok_state_type state_ff, state_in;
   res_set_type   step_results;
   res_entry_type head;
   logic [1:0]    count;
   logic          req_fire;
   logic          rsp_fire;

   // The register can be reloaded when empty, or when its one remaining beat
   // leaves in this cycle.
   assign req_chan.ready = (count == 2'd0) || (count == 2'd1 && rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   swt_step u_step (
      .state_cur    (state_ff),
      .in_byte      (req_chan.in_byte),
      .end_of_input (req_chan.end_of_input),
      .state_nxt    (state_in),
      .results      (step_results)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   swt_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .load     (req_fire),
      .load_set (step_results),
      .pop      (rsp_fire),
      .head     (head),
      .count    (count)
   );

   assign rsp_chan.valid    = (count != 2'd0);
   assign rsp_chan.out_byte = head.out_byte;
   assign rsp_chan.word_end = head.word_end;
   assign rsp_chan.last     = (count == 2'd1);

   // A backslash waits for lookahead only inside double quotes.
   a_pending_in_double: assert property (@(posedge clock) disable iff (reset)
      state_ff.pending_backslash |-> state_ff.in_double)
      else $error("pending backslash outside double quotes");

   // An unquoted escape never coexists with an open quote.
   a_escape_unquoted: assert property (@(posedge clock) disable iff (reset)
      state_ff.escape_next |-> (!state_ff.in_single && !state_ff.in_double))
      else $error("escape pending inside quotes");

   // A new byte is never taken while beats of the previous byte would be lost.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (count == 2'd0 || rsp_fire))
      else $error("result register overwritten");

   // After end of line every quoting flag is back at idle.
   a_line_reset: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.end_of_input) |=> (state_ff == '0))
      else $error("state not cleared at end of line");

endmodule
`default_nettype wire

### verif/shell_word_tokenizer_tb.sv
`timescale 1ns / 1ps

module shell_word_tokenizer_tb;
   import swt_pkg::*;

   // One result beat as the receiver should see it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       word_end;
      logic       last;
   } beat_type;

   // One command-line byte waiting to be sent. A byte flagged hold_for_drain
   // is not offered until every earlier result beat has come back.
   typedef struct packed {
      logic [7:0] code;
      logic       eoi;
      logic       hold_for_drain;
   } line_byte_type;

   localparam logic LINE_MID = 1'b0;
   localparam logic LINE_END = 1'b1;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int MAX_REPORTED = 10;

   // Hand-picked lines, each entry is {end_of_input, byte}. They hit the byte
   // extremes, every whitespace class, single quotes around a backslash and a
   // double quote, every escape inside double quotes, a backslash inside
   // double quotes that is the final byte, an escaped space, a dangling
   // unquoted escape at the end of a line, a final byte that causes nothing,
   // and a byte that causes three beats.
   localparam int DIRECTED_COUNT = 27;
   localparam logic [8:0] DIRECTED_BYTES [DIRECTED_COUNT] = '{
      {LINE_MID, 8'h00}, {LINE_MID, CH_TAB}, {LINE_MID, 8'hFF}, {LINE_MID, 8'h0B},
      {LINE_MID, 8'h0C}, {LINE_MID, 8'h0A}, {LINE_END, CH_CR},
      {LINE_MID, CH_SQUOTE}, {LINE_MID, CH_BACKSLASH}, {LINE_MID, CH_DQUOTE},
      {LINE_MID, CH_SQUOTE}, {LINE_END, CH_DOLLAR},
      {LINE_MID, CH_DQUOTE}, {LINE_MID, CH_BACKSLASH}, {LINE_MID, CH_DQUOTE},
      {LINE_MID, CH_BACKSLASH}, {LINE_MID, CH_DOLLAR}, {LINE_MID, CH_BACKSLASH},
      {LINE_MID, CH_BACKSLASH}, {LINE_MID, CH_BACKSLASH}, {LINE_END, 8'h61},
      {LINE_MID, CH_BACKSLASH}, {LINE_MID, CH_SPACE}, {LINE_MID, CH_DQUOTE},
      {LINE_END, CH_BACKSLASH},
      {LINE_MID, 8'h61}, {LINE_END, CH_BACKSLASH}
   };

   logic clock;
   logic reset = 1'b1;

   // Testbench-owned copies of the block's inputs, known from time zero.
   logic       drv_valid = 1'b0;
   logic [7:0] drv_byte  = 8'h00;
   logic       drv_eoi   = 1'b0;
   logic       sink_ready = 1'b0;

   swt_req_if req_bus ();
   swt_rsp_if rsp_bus ();

   assign req_bus.valid        = drv_valid;
   assign req_bus.in_byte      = drv_byte;
   assign req_bus.end_of_input = drv_eoi;
   assign rsp_bus.ready        = sink_ready;

   shell_word_tokenizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Bytes waiting to be sent, and result beats still owed by the block.
   line_byte_type line_bytes [$];
   beat_type      expected_beats [$];
   beat_type      byte_beats [$];

   // Quoting state of the predictor, mirroring the block's own.
   tok_state_type word_state = '0;

   // Knobs set by the stimulus sequence between phases (at the falling edge).
   bit          gaps_on = 1'b0;
   int unsigned stall_pct = 0;
   int          hold_requests = 0;

   logic all_drained = 1'b1;

   int error_count = 0;
   int bytes_sent = 0;
   int lines_sent = 0;
   int beats_checked = 0;
   int words_closed = 0;
   int triple_bytes = 0;

   int burst_left = 0;
   int gap_left = 0;
   int run_left = 0;
   int hold_left = 0;
   int holds_served = 0;
   int idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic bit is_blank(logic [7:0] code);
      case (code)
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // A kept character opens (or extends) the current word.
   function automatic void append_char(logic [7:0] code);
      if (byte_beats.size() < MAX_RESULTS)
         byte_beats.insert(byte_beats.size(), beat_type'{code, 1'b0, 1'b0});
      word_state.word_open = 1'b1;
   endfunction

   // Closing is a no-op when nothing has been kept, so empty words vanish.
   function automatic void end_word();
      if (word_state.word_open) begin
         if (byte_beats.size() < MAX_RESULTS)
            byte_beats.insert(byte_beats.size(), beat_type'{8'h00, 1'b1, 1'b0});
         word_state.word_open = 1'b0;
         words_closed++;
      end
   endfunction

   // Plain handling of a byte, with no escape or lookahead in effect.
   function automatic void scan_byte(logic [7:0] code, logic eoi);
      if (code == CH_BACKSLASH) begin
         if (word_state.in_single) begin
            append_char(code);
         end else if (word_state.in_double) begin
            // Inside double quotes the backslash waits for the next byte,
            // unless the line ends here, in which case it is kept as is.
            if (eoi)
               append_char(code);
            else
               word_state.pending_backslash = 1'b1;
         end else begin
            word_state.escape_next = 1'b1;
         end
      end else if (code == CH_SQUOTE && !word_state.in_double) begin
         word_state.in_single = ~word_state.in_single;
      end else if (code == CH_DQUOTE && !word_state.in_single) begin
         word_state.in_double = ~word_state.in_double;
      end else if (is_blank(code) && !word_state.in_single && !word_state.in_double) begin
         end_word();
      end else begin
         append_char(code);
      end
   endfunction

   // Works out every beat that one accepted byte causes and queues them.
   function automatic void predict_beats(logic [7:0] code, logic eoi);
      byte_beats.delete();
      if (word_state.escape_next) begin
         word_state.escape_next = 1'b0;
         word_state.pending_backslash = 1'b0;
         append_char(code);
      end else if (word_state.pending_backslash) begin
         // Only a double quote, a backslash or a dollar sign is escaped here;
         // anything else keeps the backslash and is then handled normally.
         word_state.pending_backslash = 1'b0;
         if (code == CH_DQUOTE || code == CH_BACKSLASH || code == CH_DOLLAR) begin
            append_char(code);
         end else begin
            append_char(CH_BACKSLASH);
            scan_byte(code, eoi);
         end
      end else begin
         scan_byte(code, eoi);
      end
      // End of line closes any open word and flushes quotes and escapes.
      if (eoi) begin
         end_word();
         word_state = '0;
      end
      if (byte_beats.size() > 0)
         byte_beats[byte_beats.size() - 1].last = 1'b1;
      if (byte_beats.size() == 3)
         triple_bytes++;
      foreach (byte_beats[i])
         expected_beats.insert(expected_beats.size(), byte_beats[i]);
   endfunction

   function automatic void note_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_REPORTED)
         $display("[%0t] %s", $realtime, msg);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Weighted toward the bytes that drive the quoting logic.
   function automatic logic [7:0] pick_char();
      int roll;
      int blank;
      roll = $urandom_range(99, 0);
      if (roll < 35)
         return 8'h61 + 8'($urandom_range(25, 0));
      if (roll < 47) begin
         blank = $urandom_range(5, 0);
         return (blank == 5) ? CH_SPACE : CH_TAB + 8'(blank);
      end
      if (roll < 59)
         return CH_BACKSLASH;
      if (roll < 67)
         return CH_SQUOTE;
      if (roll < 77)
         return CH_DQUOTE;
      if (roll < 82)
         return CH_DOLLAR;
      return 8'($urandom_range(255, 0));
   endfunction

   // Queues whole lines until roughly byte_budget bytes are waiting. Most
   // lines are short and quote-heavy; a few are long, and one in ten is raw
   // noise over the full byte range.
   task automatic queue_random_lines(input int byte_budget, input bit with_drain);
      int            len;
      bit            noise;
      bit            drain;
      bit            first_line;
      line_byte_type item;
      first_line = 1'b1;
      while (byte_budget > 0) begin
         len   = ($urandom_range(9, 0) == 0) ? 32 : $urandom_range(14, 1);
         noise = ($urandom_range(9, 0) == 0);
         drain = with_drain && (first_line || $urandom_range(2, 0) == 0);
         for (int i = 0; i < len; i++) begin
            item.code = noise ? 8'($urandom_range(255, 0)) : pick_char();
            item.eoi = (i == len - 1);
            item.hold_for_drain = drain && (i == 0);
            line_bytes.insert(line_bytes.size(), item);
         end
         lines_sent++;
         byte_budget -= len;
         first_line = 1'b0;
      end
   endtask

   // Returns at a falling edge once every byte is sent and every beat is back.
   task automatic wait_idle();
      @(negedge clock);
      while (line_bytes.size() != 0 || expected_beats.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Sender: bursts of random length with random gaps in between. A byte
   // flagged for drain is held back until all owed beats have arrived.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit took;
      if (reset) begin
         drv_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         took = drv_valid && req_bus.ready;
         if (took) begin
            void'(line_bytes.pop_front());
            bytes_sent++;
            if (burst_left > 0)
               burst_left--;
            if (burst_left == 0 && gaps_on)
               gap_left = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 10)
                                                      : $urandom_range(4, 1);
         end
         // A beat on offer stays put until the block takes it. The drain flag
         // is registered, so a held byte also waits out the edge at which
         // its predecessor was taken.
         if (!drv_valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               drv_valid <= 1'b0;
            end else if (line_bytes.size() > 0 &&
                         !(line_bytes[0].hold_for_drain && (took || !all_drained))) begin
               if (burst_left == 0)
                  burst_left = $urandom_range(16, 1);
               drv_valid <= 1'b1;
               drv_byte  <= line_bytes[0].code;
               drv_eoi   <= line_bytes[0].eoi;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: runs of ready or stall at a rate set per phase, plus a long
   // hold-off each time the stimulus sequence asks for one.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
         run_left <= 0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         sink_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left <= LONG_HOLD_CYCLES;
         sink_ready <= 1'b0;
      end else if (run_left > 0) begin
         run_left <= run_left - 1;
      end else begin
         run_left <= $urandom_range(5, 0);
         sink_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each result beat against the oldest owed beat, then
   // predicts the beats of any byte accepted at the same edge. Doing both in
   // one process keeps the queue order independent of scheduling.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      beat_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
               note_mismatch($sformatf("unexpected beat: byte %02h end %0b last %0b",
                                       rsp_bus.out_byte, rsp_bus.word_end, rsp_bus.last));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_bus.out_byte !== want.out_byte || rsp_bus.word_end !== want.word_end ||
                   rsp_bus.last !== want.last)
                  note_mismatch($sformatf(
                     "beat %0d: expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
                     beats_checked, want.out_byte, want.word_end, want.last,
                     rsp_bus.out_byte, rsp_bus.word_end, rsp_bus.last));
            end
         end
         if (req_bus.valid && req_bus.ready)
            predict_beats(req_bus.in_byte, req_bus.end_of_input);
         all_drained <= (expected_beats.size() == 0);
      end
   end

   // Watchdog: too long without a beat on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles, %0d beats still owed",
                     WATCHDOG_LIMIT, expected_beats.size());
            $display("** shell_word_tokenizer: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------------
   initial begin
      line_byte_type item;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed lines, with no idling on either side.
      @(negedge clock);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         item.code = DIRECTED_BYTES[i][7:0];
         item.eoi = DIRECTED_BYTES[i][8];
         item.hold_for_drain = 1'b0;
         line_bytes.insert(line_bytes.size(), item);
      end
      lines_sent += 5;
      wait_idle();

      // Full rate in both directions.
      queue_random_lines(100, 1'b0);
      wait_idle();

      // Bursty sender against a receiver that stalls about a third of the time.
      gaps_on = 1'b1;
      stall_pct = 35;
      queue_random_lines(120, 1'b0);
      wait_idle();

      // The receiver holds off for a long stretch while the sender keeps
      // offering bytes, so the block fills up and drops its input ready.
      gaps_on = 1'b0;
      stall_pct = 0;
      queue_random_lines(70, 1'b0);
      hold_requests++;
      wait_idle();

      // Heavy stalls, with the sender pausing at some line starts until
      // every owed beat has been returned.
      gaps_on = 1'b1;
      stall_pct = 60;
      queue_random_lines(120, 1'b1);
      wait_idle();

      // A few more cycles so that any stray beat is still caught.
      repeat (4) @(posedge clock);

      $display("Sent %0d bytes in %0d lines, checked %0d beats (%0d words, %0d triple-beat bytes)",
               bytes_sent, lines_sent, beats_checked, words_closed, triple_bytes);
      $display("Mismatches: %0d", error_count);
      if (error_count == 0)
         $display("** shell_word_tokenizer: PASSED **");
      else
         $display("** shell_word_tokenizer: FAILED **");
      $finish;
   end

endmodule
